@@ rtl/gray_sobel_edge_threshold_macros.svh @@
// Assertion macros for the gray/Sobel edge block.
`ifndef GRAY_SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define GRAY_SOBEL_EDGE_THRESHOLD_MACROS_SVH
`ifndef SYNTH
`define GSED_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsed assertion failed");
`define GSED_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsed assertion failed");
`else
`define GSED_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GSED_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/gsed_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gsed_pkg;

   localparam int PIX_W    = 8;
   localparam int THR_W    = 11;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int ROW_W    = 12;
   localparam int MIN_DIM  = 3;
   localparam int MAX_HEIGHT = 4096;
   localparam int GRAD_W   = 11;
   localparam int SQ_W     = 20;
   localparam int MAG_W    = 21;
   localparam int LIMIT_W  = 22;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;

   localparam logic [THR_W-1:0]    THRESHOLD_RESET = 11'd80;
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 11'd400;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 13'd400;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      pix_type blue;
      pix_type green;
      pix_type red;
   } rgb_type;

   // 3x3 window, pRC with row 0 two rows up and column 0 two columns left
   typedef struct packed {
      pix_type p00;
      pix_type p01;
      pix_type p02;
      pix_type p10;
      pix_type p12;
      pix_type p20;
      pix_type p21;
      pix_type p22;
   } win_type;

   typedef struct packed {
      logic edge_valid;
      logic end_of_frame;
   } tag_type;

   typedef struct packed {
      logic accept;
      logic shift;
      logic load;
   } lw_ctl_type;

   typedef struct packed {
      logic load_grad;
      logic load_square;
   } grad_ctl_type;

   function automatic pix_type gray_of(rgb_type px);
      logic [24:0] acc;
      acc = 25'(px.red) * 25'd19595 + 25'(px.green) * 25'd38470
          + 25'(px.blue) * 25'd7471 + 25'd32768;
      return acc[23:16];
   endfunction

endpackage
`default_nettype wire

@@ rtl/gray_sobel_edge_threshold.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "gray_sobel_edge_threshold_macros.svh"
// Channel   Direction  Transfer                        Content
// req_*     in         tvalid & tready                 one RGB pixel, raster order
// rsp_*     out        tvalid & tready                 gray, edge of (row-1,col-1), frame end
// csr_*     in         psel & penable & pwrite         threshold, width, height
//
// One pixel per clock sustained while rsp_tready stays high; five registered stages to rsp_tvalid.
// Line buffer: one RAM, read at input transfer, written back one stage later.
// Five-stage pipeline with per-stage valid; a held result stalls stages only as far back
// as needed, empty stages keep accepting.
// Reset clears counters and pipeline valids; line buffer RAM is not cleared.
module gray_sobel_edge_threshold #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red, green, blue
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // gray, edge_flag, zero pad
   output logic             rsp_tuser,   // edge_valid
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > gsed_pkg::WIDTH_W) ? CW + 1 : gsed_pkg::WIDTH_W;
   localparam int HW = gsed_pkg::HEIGHT_W;

   logic [gsed_pkg::THR_W-1:0]    threshold_ff;
   logic [gsed_pkg::WIDTH_W-1:0]  width_ff;
   logic [HW-1:0]                 height_ff;
   logic [gsed_pkg::LIMIT_W-1:0]  limit_ff;
   logic [gsed_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                          csr_wr;

   logic [CW-1:0]              col_ff;
   logic [CW-1:0]              col_in;
   logic [gsed_pkg::ROW_W-1:0] row_ff;
   logic [gsed_pkg::ROW_W-1:0] row_in;
   logic [LW-1:0]              width_req;
   logic [LW-1:0]              width_lim;
   logic [HW-1:0]              height_lim;
   logic                       last_col;
   logic                       last_row;
   logic                       accept;

   logic v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy_out;
   gsed_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   gsed_pkg::tag_type tag_in;
   gsed_pkg::pix_type gray3_ff, gray4_ff;

   gsed_pkg::lw_ctl_type   lw_ctl;
   gsed_pkg::grad_ctl_type grad_ctl;
   gsed_pkg::win_type      win;
   logic                   over;

   gsed_pkg::pix_type rsp_gray_ff;
   logic              rsp_flag_ff;
   logic              rsp_valid_ff;
   logic              rsp_eof_ff;

   // configuration
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= gsed_pkg::THRESHOLD_RESET;
         width_ff     <= gsed_pkg::WIDTH_RESET;
         height_ff    <= gsed_pkg::HEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            gsed_pkg::REG_EDGE_THRESHOLD: threshold_ff <= csr_pwdata[gsed_pkg::THR_W-1:0];
            gsed_pkg::REG_IMAGE_WIDTH:    width_ff     <= csr_pwdata[gsed_pkg::WIDTH_W-1:0];
            gsed_pkg::REG_IMAGE_HEIGHT:   height_ff    <= csr_pwdata[HW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         gsed_pkg::REG_EDGE_THRESHOLD: csr_prdata = 32'(threshold_ff);
         gsed_pkg::REG_IMAGE_WIDTH:    csr_prdata = 32'(width_ff);
         gsed_pkg::REG_IMAGE_HEIGHT:   csr_prdata = 32'(height_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      limit_ff <= gsed_pkg::LIMIT_W'(threshold_ff) * gsed_pkg::LIMIT_W'(threshold_ff)
                + gsed_pkg::LIMIT_W'(threshold_ff);
   end

   // raster position
   always_comb begin
      width_req = LW'(width_ff);
      if (width_req < LW'(gsed_pkg::MIN_DIM)) begin
         width_lim = LW'(gsed_pkg::MIN_DIM);
      end else if (width_req > LW'(MAX_WIDTH)) begin
         width_lim = LW'(MAX_WIDTH);
      end else begin
         width_lim = width_req;
      end
      if (height_ff < HW'(gsed_pkg::MIN_DIM)) begin
         height_lim = HW'(gsed_pkg::MIN_DIM);
      end else if (height_ff > HW'(gsed_pkg::MAX_HEIGHT)) begin
         height_lim = HW'(gsed_pkg::MAX_HEIGHT);
      end else begin
         height_lim = height_ff;
      end
      last_col = (LW'(col_ff) + LW'(1)) >= width_lim;
      last_row = (HW'(row_ff) + HW'(1)) >= height_lim;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + gsed_pkg::ROW_W'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
      tag_in.edge_valid   = (row_ff >= gsed_pkg::ROW_W'(2)) && (col_ff >= CW'(2));
      tag_in.end_of_frame = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // pipeline control
   assign rdy_out    = !out_v_ff || rsp_tready;
   assign rdy4       = !v4_ff || rdy_out;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign accept     = req_tvalid && rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1)    v1_ff    <= req_tvalid;
         if (rdy2)    v2_ff    <= v1_ff;
         if (rdy3)    v3_ff    <= v2_ff;
         if (rdy4)    v4_ff    <= v3_ff;
         if (rdy_out) out_v_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) tag1_ff <= tag_in;
      if (rdy2) tag2_ff <= tag1_ff;
      if (rdy3) begin
         tag3_ff  <= tag2_ff;
         gray3_ff <= win.p22;
      end
      if (rdy4) begin
         tag4_ff  <= tag3_ff;
         gray4_ff <= gray3_ff;
      end
      if (rdy_out) begin
         rsp_gray_ff  <= gray4_ff;
         rsp_valid_ff <= tag4_ff.edge_valid;
         rsp_flag_ff  <= tag4_ff.edge_valid && over;
         rsp_eof_ff   <= tag4_ff.end_of_frame;
      end
   end

   assign lw_ctl.accept = accept;
   assign lw_ctl.shift  = v1_ff && rdy2;
   assign lw_ctl.load   = rdy2;

   assign grad_ctl.load_grad   = rdy3;
   assign grad_ctl.load_square = rdy4;

   gsed_line_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_window (
      .clock (clock),
      .reset (reset),
      .ctl   (lw_ctl),
      .pix   (gsed_pkg::rgb_type'(req_tdata)),
      .col   (col_ff),
      .win   (win)
   );

   gsed_grad u_grad (
      .clock (clock),
      .ctl   (grad_ctl),
      .win   (win),
      .limit (limit_ff),
      .over  (over)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'b0, rsp_flag_ff, rsp_gray_ff};
   assign rsp_tuser  = rsp_valid_ff;
   assign rsp_tlast  = rsp_eof_ff;

   `GSED_ASSERT_NXT(a_col_wrap, clock, reset, accept && last_col, col_ff == '0)
   `GSED_ASSERT_NXT(a_frame_wrap, clock, reset, accept && tag_in.end_of_frame, col_ff == '0 && row_ff == '0)
   `GSED_ASSERT_IMP(a_flag_needs_valid, clock, reset, out_v_ff && rsp_flag_ff, rsp_valid_ff)

endmodule
`default_nettype wire

@@ rtl/gsed_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gsed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/gsed_line_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "gray_sobel_edge_threshold_macros.svh"
module gsed_line_window #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire gsed_pkg::lw_ctl_type         ctl,
   input  wire gsed_pkg::rgb_type            pix,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
   output gsed_pkg::win_type                 win
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = 2 * gsed_pkg::PIX_W;

   gsed_pkg::rgb_type  rgb_ff;
   logic [CW-1:0]      col_ff;
   gsed_pkg::pix_type  win_col_ff [6];
   gsed_pkg::pix_type  win_col_in [6];
   gsed_pkg::win_type  win_ff;
   gsed_pkg::win_type  win_in;
   gsed_pkg::pix_type  gray;
   gsed_pkg::pix_type  top;
   gsed_pkg::pix_type  mid;
   logic [LW-1:0]      rd_data;

   gsed_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ctl.shift),
      .wr_addr (col_ff),
      .wr_data ({mid, gray}),
      .rd_en   (ctl.accept),
      .rd_addr (col),
      .rd_data (rd_data)
   );

   // upper row in the high byte, middle row in the low byte
   assign top  = rd_data[LW-1:gsed_pkg::PIX_W];
   assign mid  = rd_data[gsed_pkg::PIX_W-1:0];
   assign gray = gsed_pkg::gray_of(rgb_ff);

   always_comb begin
      win_in.p00 = win_col_ff[0];
      win_in.p10 = win_col_ff[1];
      win_in.p20 = win_col_ff[2];
      win_in.p01 = win_col_ff[3];
      win_in.p21 = win_col_ff[5];
      win_in.p02 = top;
      win_in.p12 = mid;
      win_in.p22 = gray;
      win_col_in[0] = win_col_ff[3];
      win_col_in[1] = win_col_ff[4];
      win_col_in[2] = win_col_ff[5];
      win_col_in[3] = top;
      win_col_in[4] = mid;
      win_col_in[5] = gray;
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         rgb_ff <= pix;
         col_ff <= col;
      end
      if (ctl.load) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_col_ff[i] <= '0;
         end
      end else if (ctl.shift) begin
         for (int i = 0; i < 6; i++) begin
            win_col_ff[i] <= win_col_in[i];
         end
      end
   end

   assign win = win_ff;

   `GSED_ASSERT_IMP(a_no_rw_collision, clock, reset, ctl.shift && ctl.accept, col_ff != col)
   `GSED_ASSERT_IMP(a_shift_loads_window, clock, reset, ctl.shift, ctl.load)

endmodule
`default_nettype wire

@@ rtl/gsed_grad.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gsed_grad (
   input  wire logic                             clock,
   input  wire gsed_pkg::grad_ctl_type           ctl,
   input  wire gsed_pkg::win_type                win,
   input  wire logic [gsed_pkg::LIMIT_W-1:0]     limit,
   output logic                                  over
);

   localparam int GW = gsed_pkg::GRAD_W;

   logic signed [GW-1:0] gx_ff;
   logic signed [GW-1:0] gy_ff;
   logic signed [GW-1:0] gx_in;
   logic signed [GW-1:0] gy_in;
   logic [gsed_pkg::SQ_W-1:0] gx2_ff;
   logic [gsed_pkg::SQ_W-1:0] gy2_ff;
   logic [gsed_pkg::SQ_W-1:0] gx2_in;
   logic [gsed_pkg::SQ_W-1:0] gy2_in;
   logic [gsed_pkg::LIMIT_W-1:0] mag;

   always_comb begin
      gx_in = (GW'(win.p02) + (GW'(win.p12) <<< 1) + GW'(win.p22))
            - (GW'(win.p00) + (GW'(win.p10) <<< 1) + GW'(win.p20));
      gy_in = (GW'(win.p20) + (GW'(win.p21) <<< 1) + GW'(win.p22))
            - (GW'(win.p00) + (GW'(win.p01) <<< 1) + GW'(win.p02));
      gx2_in = gsed_pkg::SQ_W'(unsigned'(22'(gx_ff * gx_ff)));
      gy2_in = gsed_pkg::SQ_W'(unsigned'(22'(gy_ff * gy_ff)));
      mag = gsed_pkg::LIMIT_W'(gx2_ff) + gsed_pkg::LIMIT_W'(gy2_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_grad) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (ctl.load_square) begin
         gx2_ff <= gx2_in;
         gy2_ff <= gy2_in;
      end
   end

   assign over = mag > limit;

endmodule
`default_nettype wire

@@ sim/gray_sobel_edge_threshold_check.sv @@
`timescale 1ns / 1ps
module gray_sobel_edge_threshold_check #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int unsigned error_count,
   output int unsigned outstanding
);

   typedef struct packed {
      logic [7:0] gray;
      logic       edge_valid;
      logic       edge_flag;
      logic       end_of_frame;
   } pixel_result_type;

   pixel_result_type pending_pixels[$];

   logic [gsed_pkg::THR_W-1:0]    threshold;
   logic [gsed_pkg::WIDTH_W-1:0]  width_reg;
   logic [gsed_pkg::HEIGHT_W-1:0] height_reg;

   logic [7:0] upper_line [MAX_WIDTH];
   logic [7:0] middle_line[MAX_WIDTH];
   logic [7:0] window_px[6];   // [0..2] column col-2, [3..5] column col-1, top to bottom
   int unsigned row_pos;
   int unsigned col_pos;

   initial begin
      error_count = 0;
      outstanding = 0;
      foreach (upper_line[i]) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic predict_pixel(input logic [23:0] px, output pixel_result_type res);
      int unsigned acc;
      int unsigned w;
      int unsigned h;
      int unsigned thr;
      int unsigned mag;
      int unsigned limit;
      int gx;
      int gy;
      int win[3][3];
      logic [7:0] gray;
      logic [7:0] upper_px;
      logic [7:0] middle_px;
      logic last_col;
      logic last_row;
      acc = 19595 * px[7:0] + 38470 * px[15:8] + 7471 * px[23:16] + 32768;
      gray = 8'(acc >> 16);
      w = (width_reg < gsed_pkg::MIN_DIM) ? gsed_pkg::MIN_DIM :
          (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg < gsed_pkg::MIN_DIM) ? gsed_pkg::MIN_DIM :
          (height_reg > gsed_pkg::MAX_HEIGHT) ? gsed_pkg::MAX_HEIGHT : height_reg;
      upper_px = upper_line[col_pos];
      middle_px = middle_line[col_pos];
      upper_line[col_pos] = middle_px;
      middle_line[col_pos] = gray;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = window_px[i];
         win[i][1] = window_px[3 + i];
      end
      win[0][2] = upper_px;
      win[1][2] = middle_px;
      win[2][2] = gray;
      res.gray = gray;
      res.edge_valid = (row_pos >= 2) && (col_pos >= 2);
      res.edge_flag = 1'b0;
      if (res.edge_valid) begin
         gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
         gy = (win[2][0] + 2 * win[2][1] + win[2][2]) - (win[0][0] + 2 * win[0][1] + win[0][2]);
         mag = gx * gx + gy * gy;
         thr = threshold;
         limit = thr * thr + thr;
         res.edge_flag = mag > limit;
      end
      for (int i = 0; i < 3; i++) window_px[i] = window_px[3 + i];
      window_px[3] = upper_px;
      window_px[4] = middle_px;
      window_px[5] = gray;
      last_col = (col_pos + 1) >= w;
      last_row = (row_pos + 1) >= h;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      res.end_of_frame = last_col && last_row;
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      logic [31:0] reg_value;
      if (reset) begin
         threshold = gsed_pkg::THRESHOLD_RESET;
         width_reg = gsed_pkg::WIDTH_RESET;
         height_reg = gsed_pkg::HEIGHT_RESET;
         foreach (window_px[i]) window_px[i] = '0;
         row_pos = 0;
         col_pos = 0;
         pending_pixels.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata, want);
            pending_pixels.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("unexpected result transfer", 0, 0);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata[7:0] !== want.gray)
                  report_mismatch("gray", rsp_tdata[7:0], want.gray);
               if (rsp_tdata[8] !== want.edge_flag)
                  report_mismatch("edge_flag", rsp_tdata[8], want.edge_flag);
               if (rsp_tuser !== want.edge_valid)
                  report_mismatch("edge_valid", rsp_tuser, want.edge_valid);
               if (rsp_tlast !== want.end_of_frame)
                  report_mismatch("end_of_frame", rsp_tlast, want.end_of_frame);
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  gsed_pkg::REG_EDGE_THRESHOLD:
                     threshold = csr_pwdata[gsed_pkg::THR_W-1:0];
                  gsed_pkg::REG_IMAGE_WIDTH:
                     width_reg = csr_pwdata[gsed_pkg::WIDTH_W-1:0];
                  gsed_pkg::REG_IMAGE_HEIGHT:
                     height_reg = csr_pwdata[gsed_pkg::HEIGHT_W-1:0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr[3:2])
                  gsed_pkg::REG_EDGE_THRESHOLD: reg_value = 32'(threshold);
                  gsed_pkg::REG_IMAGE_WIDTH:    reg_value = 32'(width_reg);
                  gsed_pkg::REG_IMAGE_HEIGHT:   reg_value = 32'(height_reg);
                  default:                      reg_value = '0;
               endcase
               if (csr_prdata !== reg_value)
                  report_mismatch("register read", csr_prdata, reg_value);
            end
         end
      end
      outstanding = pending_pixels.size();
   end

endmodule

@@ sim/gray_sobel_edge_threshold_test.sv @@
`timescale 1ns / 1ps
module gray_sobel_edge_threshold_test;

   localparam int LINE_MAX = 1024;
   localparam int HOLD_CYCLES = 400;

   typedef enum int {FILL_NOISE, FILL_FLAT, FILL_STEP} fill_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;     // red, green, blue
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // gray, edge_flag, zero pad
   logic        rsp_tuser;          // edge_valid
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned error_count;
   int unsigned outstanding;

   bit hold_req = 1'b0;
   bit burst = 1'b0;
   int frame_width = 400;
   int frame_height = 400;
   int pix_row = 0;
   int pix_col = 0;

   always #5 clock = ~clock;

   gray_sobel_edge_threshold #(
      .MAX_WIDTH(LINE_MAX)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   gray_sobel_edge_threshold_check #(
      .MAX_WIDTH(LINE_MAX)
   ) u_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .error_count(error_count),
      .outstanding(outstanding)
   );

   function automatic int clamp_dim(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_threshold();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1443;
         2: return 2047;
         3: return 1442;
         4: return $urandom_range(0, 1443);
         default: return $urandom_range(0, 300);
      endcase
   endfunction

   function automatic logic [23:0] make_pixel(fill_kind_type fill, int row, int col, int base,
                                              int split);
      logic [7:0] chan[3];
      case (fill)
         FILL_NOISE: return 24'($urandom);
         FILL_FLAT:
            foreach (chan[i]) chan[i] = 8'(base + $urandom_range(0, 15));
         default:
            foreach (chan[i])
               chan[i] = ((col >= split) != (row >= split)) ?
                         8'(200 + $urandom_range(0, 55)) : 8'($urandom_range(0, 40));
      endcase
      return {chan[2], chan[1], chan[0]};
   endfunction

   task automatic send_pixel(input logic [23:0] px);
      int gap;
      gap = burst ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (pix_col + 1 >= frame_width) begin
         pix_col = 0;
         pix_row = (pix_row + 1 >= frame_height) ? 0 : pix_row + 1;
      end else begin
         pix_col++;
      end
   endtask

   // block drained, plus pipeline slack
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_read(input logic [1:0] idx);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         gsed_pkg::REG_IMAGE_WIDTH:
            frame_width = clamp_dim(value[gsed_pkg::WIDTH_W-1:0], gsed_pkg::MIN_DIM, LINE_MAX);
         gsed_pkg::REG_IMAGE_HEIGHT:
            frame_height = clamp_dim(value[gsed_pkg::HEIGHT_W-1:0], gsed_pkg::MIN_DIM,
                                     gsed_pkg::MAX_HEIGHT);
         default: ;
      endcase
      csr_read(idx);
   endtask

   // result side: random stalls, long ready stretches, and forced hold-offs
   initial begin
      int ready_left;
      int roll;
      ready_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            ready_left = 0;
         end
         if (ready_left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               rsp_tready <= 1'b1;
               ready_left = $urandom_range(0, 15);
            end else if (roll < 80) begin
               rsp_tready <= 1'b0;
               ready_left = $urandom_range(0, 2);
            end else if (roll < 92) begin
               rsp_tready <= 1'b1;
               ready_left = $urandom_range(50, 200);
            end else begin
               rsp_tready <= 1'b0;
               ready_left = $urandom_range(10, 50);
            end
         end else begin
            ready_left--;
         end
      end
   end

   initial begin
      #50_000_000;
      $display("gray_sobel_edge_threshold test failed");
      $finish;
   end

   initial begin
      logic [23:0] directed_px[16];
      fill_kind_type fill;
      int base;
      int split;
      int change_at;
      int n;
      int random_sent;
      int roll;

      directed_px = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                      24'hFF0000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                      24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                      24'h808080, 24'h7F7F7F, 24'h101010, 24'hEFEFEF};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read(gsed_pkg::REG_EDGE_THRESHOLD);
      csr_read(gsed_pkg::REG_IMAGE_WIDTH);
      csr_read(gsed_pkg::REG_IMAGE_HEIGHT);

      // reset threshold and height, narrow rows; height cut below the current row mid-frame
      set_register(gsed_pkg::REG_IMAGE_WIDTH, 4);
      for (int i = 0; i < 12; i++) send_pixel(directed_px[i]);
      wait_idle();
      set_register(gsed_pkg::REG_IMAGE_HEIGHT, 3);
      for (int i = 12; i < 16; i++) send_pixel(directed_px[i]);

      // zero threshold on a flat minimal frame: magnitude equals the limit
      wait_idle();
      set_register(gsed_pkg::REG_EDGE_THRESHOLD, 0);
      set_register(gsed_pkg::REG_IMAGE_WIDTH, 3);
      repeat (9) send_pixel(24'h070707);

      random_sent = 0;
      while (random_sent < 300) begin
         if ($urandom_range(0, 3) != 0) begin
            wait_idle();
            if ($urandom_range(0, 1) == 0)
               set_register(gsed_pkg::REG_EDGE_THRESHOLD, pick_threshold());
            if ($urandom_range(0, 9) < 6) begin
               roll = $urandom_range(0, 99);
               set_register(gsed_pkg::REG_IMAGE_WIDTH, (roll < 10) ? $urandom_range(0, 2) :
                            (roll < 85) ? $urandom_range(3, 12) : $urandom_range(13, 40));
            end
            if ($urandom_range(0, 9) < 6) begin
               roll = $urandom_range(0, 99);
               set_register(gsed_pkg::REG_IMAGE_HEIGHT, (roll < 10) ? $urandom_range(0, 2) :
                            (roll < 90) ? $urandom_range(3, 8) : $urandom_range(9, 16));
            end
         end
         fill = fill_kind_type'($urandom_range(0, 2));
         base = $urandom_range(0, 240);
         split = $urandom_range(1, 8);
         burst = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 29) == 0) hold_req = 1'b1;
         change_at = ($urandom_range(0, 3) == 0) ?
                     $urandom_range(1, frame_width * frame_height - 1) : -1;
         n = 0;
         do begin
            if (n == change_at) begin
               wait_idle();
               case ($urandom_range(0, 2))
                  0: set_register(gsed_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 12));
                  1: set_register(gsed_pkg::REG_IMAGE_WIDTH, $urandom_range(0, frame_width));
                  default: set_register(gsed_pkg::REG_EDGE_THRESHOLD, pick_threshold());
               endcase
            end
            send_pixel(make_pixel(fill, pix_row, pix_col, base, split));
            n++;
            random_sent++;
         end while (pix_row != 0 || pix_col != 0);
      end
      burst = 1'b0;

      // oversized width saturates, first under a long result hold-off with the input kept
      // busy; then narrowed mid-row so the column wraps past the new limit
      wait_idle();
      set_register(gsed_pkg::REG_EDGE_THRESHOLD, $urandom_range(0, 400));
      set_register(gsed_pkg::REG_IMAGE_WIDTH, 2047);
      set_register(gsed_pkg::REG_IMAGE_HEIGHT, 3);
      split = $urandom_range(1, 4);
      hold_req = 1'b1;
      burst = 1'b1;
      for (int i = 0; i < LINE_MAX + 6; i++) begin
         if (i == 300) burst = 1'b0;
         send_pixel(make_pixel(FILL_STEP, pix_row, pix_col, 0, split));
      end
      burst = 1'b0;
      wait_idle();
      set_register(gsed_pkg::REG_IMAGE_WIDTH, 5);
      do send_pixel(make_pixel(FILL_STEP, pix_row, pix_col, 0, split));
      while (pix_row != 0 || pix_col != 0);

      // oversized height saturates; cut mid-frame so the row wraps past the new limit
      wait_idle();
      set_register(gsed_pkg::REG_EDGE_THRESHOLD, 1443);
      set_register(gsed_pkg::REG_IMAGE_WIDTH, 3);
      set_register(gsed_pkg::REG_IMAGE_HEIGHT, 8191);
      burst = 1'b1;
      repeat (36) send_pixel(make_pixel(FILL_NOISE, pix_row, pix_col, 0, 0));
      burst = 1'b0;
      wait_idle();
      set_register(gsed_pkg::REG_IMAGE_HEIGHT, 3);
      do send_pixel(make_pixel(FILL_NOISE, pix_row, pix_col, 0, 0));
      while (pix_row != 0 || pix_col != 0);

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("gray_sobel_edge_threshold test passed");
      end else begin
         $display("gray_sobel_edge_threshold test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gsed_pkg.sv
rtl/gsed_ram.sv
rtl/gsed_line_window.sv
rtl/gsed_grad.sv
rtl/gray_sobel_edge_threshold.sv
sim/gray_sobel_edge_threshold_check.sv
sim/gray_sobel_edge_threshold_test.sv
